// ----- hw/rtl/pxh_pkg.sv -----
`timescale 1ns / 1ps

package pxh_pkg;

  // width of the result fields on the port
  localparam int unsigned FIELD_W = 24;

  // command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
    logic [7:0] bin_index;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] bin_count;
    logic [FIELD_W-1:0] max_count;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic clr_wr;   // clear sweep write, one bin per cycle
    logic rd_en;    // read the selected bin
    logic update;   // write back, update max, load output
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic req_fs;    // incoming request carries frame start
    logic clr_last;  // sweep is at its last bin
    logic out_free;  // output register can take a result
  } stat_t;

  function automatic logic [FIELD_W-1:0] to_field(logic [31:0] v);
    return v[FIELD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/pxh_ram.sv -----
`timescale 1ns / 1ps

module pxh_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pxh_ctrl.sv -----
`timescale 1ns / 1ps

module pxh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pxh_pkg::stat_t stat_i,
  output pxh_pkg::ctrl_t ctrl_o
);

  localparam logic [2:0] ST_INIT  = 3'd0;  // sweep after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;  // sweep for frame start
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_INIT: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = stat_i.req_fs ? ST_CLEAR : ST_READ;
        end
      end
      ST_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.update = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/pxh_dp.sv -----
`timescale 1ns / 1ps

module pxh_dp #(
  parameter int unsigned BIN_COUNT   = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pxh_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pxh_pkg::out_rsp_t out_rsp_o,
  input  pxh_pkg::ctrl_t    ctrl_i,
  output pxh_pkg::stat_t    stat_o
);

  localparam int unsigned AW = $clog2(BIN_COUNT);
  localparam logic [31:0] BIN_LIMIT = 32'(BIN_COUNT);
  localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);

  pxh_pkg::in_req_t  item_q;
  pxh_pkg::out_rsp_t rsp_q;
  logic              out_valid_q;
  logic [AW-1:0]     clr_cnt_q;
  logic [COUNT_WIDTH-1:0] max_q, max_d;

  logic [7:0]             sel;
  logic [31:0]            sel_wide;
  logic                   in_range;
  logic                   is_read;
  logic [AW-1:0]          addr;
  logic [COUNT_WIDTH-1:0] cur, inc, result;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   bump;

  // request register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= in_req_i;
    end
  end

  assign is_read  = (item_q.cmd == pxh_pkg::CMD_READ);
  assign sel      = is_read ? item_q.bin_index : item_q.pixel;
  assign sel_wide = 32'(sel);
  assign in_range = (sel_wide < BIN_LIMIT);
  assign addr     = sel_wide[AW-1:0];

  // clear sweep counter
  assign stat_o.clr_last = (clr_cnt_q == LAST_BIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_wr) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // bin store
  assign cur  = ram_rdata;
  assign inc  = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);  // saturate
  assign bump = ctrl_i.update && !is_read && in_range;

  assign ram_we    = ctrl_i.clr_wr || bump;
  assign ram_waddr = ctrl_i.clr_wr ? clr_cnt_q : addr;
  assign ram_wdata = ctrl_i.clr_wr ? '0 : inc;

  pxh_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(BIN_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  assign result = !in_range ? '0 : (is_read ? cur : inc);

  // running maximum
  always_comb begin
    max_d = max_q;
    if (ctrl_i.clr_wr) begin
      max_d = '0;
    end else if (bump && (inc > max_q)) begin
      max_d = inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  // output register
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.req_fs   = in_req_i.frame_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      rsp_q.bin_count <= pxh_pkg::to_field(32'(result));
      rsp_q.max_count <= pxh_pkg::to_field(32'(max_d));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- hw/rtl/pixel_histogram_256_top.sv -----
`timescale 1ns / 1ps
// Gray-level histogram with BIN_COUNT bins of COUNT_WIDTH-bit saturating counts.
// Input channel: in_valid_i / in_stall_o with in_req_i. A request either counts
// its pixel (cmd = accumulate) or reads bin_index (cmd = read). frame_start
// zeroes all bins and the maximum before the request takes effect.
// Output channel: out_valid_o / out_stall_i with out_rsp_o, one response per
// request: the bin count after the update and the largest count so far.
// Flow: a request is taken only while the block is idle; after acceptance it
// passes a read state, then a respond state that registers the response,
// and only then can the block take the next request. The bin RAM (one
// read, one write port) sets this: capture, RAM read, then modify and write.
// A frame-start request adds a sweep that zeroes every bin of the RAM.
// Reset: the same sweep runs after reset, with in_stall_o high.
// Stall: the response sits in the output register; a new request may still be
// accepted, and it waits in its last step until the register frees up.
module pixel_histogram_256_top #(
  parameter int unsigned BIN_COUNT   = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pxh_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pxh_pkg::out_rsp_t out_rsp_o
);

  pxh_pkg::ctrl_t ctrl;
  pxh_pkg::stat_t stat;

  // sequencer: sweep, idle, read, respond
  pxh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  // request register, bin RAM, sweep counter, max register, output register
  pxh_dp #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .ctrl_i     (ctrl),
    .stat_o     (stat)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned BINS        = 256;
  localparam int unsigned CNT_W       = 24;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam int unsigned RANDOM_REQS = 730;
  // long output hold-off, counted in the response process
  localparam int unsigned HOLD_CYCLES = 300;
  // worst case per request: frame-start sweep, the request's own states, the
  // longest sender gap and the longest stall run; the sum over about 750
  // requests plus the hold-off and the reset sweep, taken ~7x over
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pxh_pkg::in_req_t   in_req;
  logic               out_valid;
  logic               out_stall;
  pxh_pkg::out_rsp_t  out_rsp;

  always #2 clk = ~clk;

  pixel_histogram_256_top #(
    .BIN_COUNT  (BINS),
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // ---------------------------------------------------------------------
  // Histogram predictor: our own copy of the bins and the running peak.
  // Saturation needs 2^24 hits on one bin, far past this run's length;
  // the update still holds a bin at full scale.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] bin_tally [BINS];
  logic [CNT_W-1:0] peak_tally;

  function automatic pxh_pkg::out_rsp_t histogram_update(pxh_pkg::in_req_t r);
    logic [CNT_W-1:0] c;
    pxh_pkg::out_rsp_t rsp;
    if (r.frame_start) begin
      foreach (bin_tally[k]) bin_tally[k] = '0;
      peak_tally = '0;
    end
    if (r.cmd == pxh_pkg::CMD_ACCUM) begin
      c = bin_tally[r.pixel];
      if (c != CNT_SAT) c = c + 1'b1;
      bin_tally[r.pixel] = c;
      if (c > peak_tally) peak_tally = c;
    end else begin
      c = bin_tally[r.bin_index];
    end
    rsp.bin_count = c;
    rsp.max_count = peak_tally;
    return rsp;
  endfunction

  // expected responses, oldest first
  pxh_pkg::out_rsp_t pending_counts [$];

  int unsigned err_cnt   = 0;
  int unsigned n_accum   = 0;
  int unsigned n_read    = 0;
  int unsigned n_fs      = 0;
  int unsigned n_checked = 0;
  logic [CNT_W-1:0] peak_seen = '0;
  int unsigned cycle_cnt = 0;

  // shared knobs: quiet turns off all idling on both sides, hold_req asks
  // the response side for one long hold-off
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  // ---------------------------------------------------------------------
  // Directed table. Rows with a typed response are read straight off the
  // histogram rules; the rest take the predictor's value.
  // ---------------------------------------------------------------------
  typedef struct {
    pxh_pkg::in_req_t  req;
    bit                typed;
    pxh_pkg::out_rsp_t rsp;
  } stim_row_t;

  stim_row_t stim_rows [$];

  function automatic void add_row(logic cmd, logic [7:0] pix, logic [7:0] idx,
                                  int unsigned fs, int unsigned typed,
                                  int unsigned bin, int unsigned peak);
    stim_row_t row;
    row.req.cmd         = cmd;
    row.req.pixel       = pix;
    row.req.bin_index   = idx;
    row.req.frame_start = fs[0];
    row.typed           = typed[0];
    row.rsp.bin_count   = bin[CNT_W-1:0];
    row.rsp.max_count   = peak[CNT_W-1:0];
    stim_rows.push_back(row);
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request at a falling edge, hold it until taken, predict on
  // acceptance. Enters and leaves on a falling edge.
  task automatic send_request(input pxh_pkg::in_req_t r, input bit typed,
                              input pxh_pkg::out_rsp_t typed_rsp);
    int unsigned gap;
    pxh_pkg::out_rsp_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    predicted = histogram_update(r);
    pending_counts.push_back(typed ? typed_rsp : predicted);
    if (r.cmd == pxh_pkg::CMD_ACCUM) n_accum++;
    else n_read++;
    if (r.frame_start) n_fs++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Response side: runs of stall / no stall, one long hold-off on request.
  // Knobs are read at the rising edge, stall changes at the falling edge.
  // ---------------------------------------------------------------------
  initial begin
    bit nxt;
    bit run_state;
    int unsigned run_left;
    int unsigned hold_left;
    out_stall = 1'b0;
    run_state = 1'b0;
    run_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        nxt = 1'b1;
        hold_left--;
      end else if (quiet) begin
        nxt = 1'b0;
      end else begin
        if (run_left == 0) begin
          run_state = ($urandom_range(0, 2) == 0);
          run_left  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                : $urandom_range(10, 40);
        end
        nxt = run_state;
        run_left--;
      end
      @(negedge clk);
      out_stall <= nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Response checker: every taken response against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pxh_pkg::out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("response with nothing pending: bin_count=%0d max_count=%0d",
               out_rsp.bin_count, out_rsp.max_count);
        err_cnt++;
      end else begin
        want = pending_counts.pop_front();
        n_checked++;
        if (out_rsp.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", want.bin_count, out_rsp.bin_count);
          err_cnt++;
        end
        if (out_rsp.max_count !== want.max_count) begin
          $error("max_count: expected %0d, got %0d", want.max_count, out_rsp.max_count);
          err_cnt++;
        end
        if (out_rsp.max_count > peak_seen) peak_seen = out_rsp.max_count;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, pending_counts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    pxh_pkg::in_req_t r;
    logic [7:0]       hot_pix [4];

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    foreach (bin_tally[k]) bin_tally[k] = '0;
    peak_tally = '0;
    foreach (hot_pix[k]) hot_pix[k] = 8'($urandom);

    //       cmd                 pix    idx    fs  typed bin peak
    add_row(pxh_pkg::CMD_READ,  8'h00, 8'h00, 0, 1, 0, 0);  // empty after reset
    add_row(pxh_pkg::CMD_READ,  8'hFF, 8'hFF, 0, 1, 0, 0);
    add_row(pxh_pkg::CMD_ACCUM, 8'h00, 8'hFF, 0, 1, 1, 1);  // lowest pixel
    add_row(pxh_pkg::CMD_ACCUM, 8'hFF, 8'h00, 0, 1, 1, 1);  // highest pixel
    add_row(pxh_pkg::CMD_ACCUM, 8'hFF, 8'h00, 0, 1, 2, 2);  // back-to-back same bin
    add_row(pxh_pkg::CMD_READ,  8'h00, 8'hFF, 0, 1, 2, 2);
    add_row(pxh_pkg::CMD_READ,  8'hFF, 8'h00, 0, 1, 1, 2);  // read below the peak
    add_row(pxh_pkg::CMD_ACCUM, 8'h00, 8'h00, 1, 1, 1, 1);  // frame start, then count
    add_row(pxh_pkg::CMD_READ,  8'h00, 8'hFF, 0, 1, 0, 1);  // old bin gone
    add_row(pxh_pkg::CMD_READ,  8'h00, 8'h80, 1, 1, 0, 0);  // frame start on a read
    add_row(pxh_pkg::CMD_ACCUM, 8'hAA, 8'h55, 0, 1, 1, 1);
    add_row(pxh_pkg::CMD_ACCUM, 8'h55, 8'hAA, 0, 1, 1, 1);
    add_row(pxh_pkg::CMD_ACCUM, 8'h55, 8'h00, 0, 1, 2, 2);
    add_row(pxh_pkg::CMD_READ,  8'h55, 8'hAA, 0, 1, 1, 2);
    add_row(pxh_pkg::CMD_ACCUM, 8'hAA, 8'hFF, 1, 1, 1, 1);
    add_row(pxh_pkg::CMD_ACCUM, 8'h80, 8'h7F, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_ACCUM, 8'h80, 8'h7F, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_ACCUM, 8'h80, 8'h01, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_ACCUM, 8'h7F, 8'hFE, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_READ,  8'h01, 8'h80, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_READ,  8'hFE, 8'h7F, 0, 0, 0, 0);
    add_row(pxh_pkg::CMD_ACCUM, 8'h01, 8'h80, 1, 1, 1, 1);
    add_row(pxh_pkg::CMD_READ,  8'h01, 8'h80, 0, 1, 0, 1);

    // hold reset, then release it; the block then sweeps its RAM with in_stall high
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[n]) send_request(stim_rows[n].req, stim_rows[n].typed, stim_rows[n].rsp);

    // Random part: frames of mostly hot pixels so counts and the peak climb,
    // sprinkled with reads of hot and arbitrary bins, cold pixels, and an
    // occasional frame start on either command.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 150) hold_req = 1'b1;  // fill the block behind a long hold-off
      quiet = (i >= 450 && i < 550);
      r.frame_start = ($urandom_range(0, 59) == 0);
      if (r.frame_start) foreach (hot_pix[k]) hot_pix[k] = 8'($urandom);
      r.cmd       = ($urandom_range(0, 3) == 0) ? pxh_pkg::CMD_READ : pxh_pkg::CMD_ACCUM;
      r.pixel     = ($urandom_range(0, 9) < 6) ? hot_pix[2'($urandom_range(0, 3))]
                                               : 8'($urandom);
      r.bin_index = ($urandom_range(0, 1) == 0) ? hot_pix[2'($urandom_range(0, 3))]
                                                : 8'($urandom);
      send_request(r, 1'b0, '0);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then watch a while for stray responses
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests (%0d accumulate, %0d read, %0d frame start), %0d checked",
             n_accum + n_read, n_accum, n_read, n_fs, n_checked);
    $display("largest bin count seen %0d; one output hold-off of %0d cycles",
             peak_seen, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
